// File: hdl/mfp_pkg.sv
// Package for the modem frame parser: beat types, op and status codes, FSM states.
// No dependencies.
`default_nettype none
package mfp_pkg;
	localparam int RingDepth = 256;
	localparam int HeaderBytes = 7;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_PARSE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_BAD_HDR = 3'd1;
	localparam logic [2:0] ST_HDR_OK = 3'd2;
	localparam logic [2:0] ST_CRC_BAD = 3'd3;
	localparam logic [2:0] ST_DATA = 3'd4;
	localparam logic [2:0] ST_REBOOT = 3'd5;
	localparam logic [2:0] ST_PUSHED = 3'd6;
	localparam logic [2:0] ST_READ = 3'd7;

	localparam logic [CfgIdxW-1:0] REG_SYNC = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_VERSION = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_POLY = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_CRC_START = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_REBOOT = 3'd4;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] frame_length;
		logic [7:0] frame_type;
		logic [7:0] data_byte;
		logic [7:0] buffered_count;
	} out_beat_t;

	typedef struct packed {
		logic [7:0] sync_value;
		logic [7:0] version_value;
		logic [15:0] crc_polynomial;
		logic [15:0] crc_start;
		logic [7:0] reboot_type_code;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_HDR_RD, S_HDR_WAIT, S_HDR_CHK, S_COPY_RD, S_COPY_WR, S_COPY_RD_N,
		S_REB_RD, S_REB_WAIT, S_PAY_RD, S_PAY_WAIT, S_DONE
	} state_t;

	function automatic logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] d,
		logic [15:0] poly);
		logic [15:0] c;
		c = c_in ^ {d, 8'h00};
		for (int b = 0; b < 8; b++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
		end
		return c;
	endfunction
endpackage
`default_nettype wire

// File: hdl/mfp_ram.sv
// Single-port-write, single-port-read byte memory, registered read data.
// Depends on nothing.
`default_nettype none
module mfp_ram #(
	parameter int Depth = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [7:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [7:0] rdata
);
	logic [7:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: hdl/modem_frame_parser_top.sv
// Modem frame parser top: ring and payload memories plus the parse sequencer.
// Depends on mfp_pkg and mfp_ram.
//
//  channel  | handshake              | payload
//  input    | start / busy           | in_beat  (mfp_pkg::in_beat_t)
//  result   | done (one-cycle pulse) | result   (mfp_pkg::out_beat_t)
//  config   | cfg_we                 | cfg_index, cfg_data
//
// Push and no-progress step: S_DONE. Read: S_PAY_RD, S_PAY_WAIT.
// Header step: S_HDR_RD, S_HDR_WAIT, S_HDR_CHK. A completing frame: S_COPY_RD, then
// S_COPY_WR and S_COPY_RD_N in turn over the payload bytes via the single ring read
// port (none if empty), then S_REB_RD, S_REB_WAIT; CRC folded in on each write.
// Reset clears pointers and header state and loads configuration defaults; memories are not cleared.
// busy is high from accept until the result beat; the receiver cannot stall.
`default_nettype none
module modem_frame_parser_top #(
	parameter int RingDepth = mfp_pkg::RingDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire mfp_pkg::in_beat_t in_beat,
	output logic done,
	output mfp_pkg::out_beat_t result,
	input wire logic cfg_we,
	input wire logic [mfp_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [mfp_pkg::CfgDataW-1:0] cfg_data
);
	localparam int AW = $clog2(RingDepth);

	mfp_pkg::cfg_t cfg_q;
	mfp_pkg::state_t state_q, state_d;
	mfp_pkg::in_beat_t cmd_q;
	logic [AW-1:0] rp_q, wp_q, off_q, rp_d, off_d;
	logic hdr_q, hdr_d;
	logic [7:0] len_q, type_q, len_d, type_d;
	logic [15:0] hcrc_q, hcrc_d, crc_q, crc_d;
	logic [7:0] b0_q, b0_d;
	logic ok_q, ok_d;
	logic [2:0] stat_d;
	logic [7:0] dout_d, flen_d;
	logic done_d;
	logic [AW-1:0] fill;
	logic [8:0] need;

	logic ring_we, pay_we;
	logic [AW-1:0] ring_ra, pay_wa, pay_ra;
	logic [7:0] ring_rd, pay_rd;

	assign fill = wp_q - rp_q;
	assign need = 9'(mfp_pkg::HeaderBytes) + {1'b0, len_q};
	assign ring_we = start && !busy && in_beat.op == mfp_pkg::OP_PUSH;

	mfp_ram #(.Depth(RingDepth)) u_ring (
		.clk(clk), .we(ring_we), .waddr(wp_q), .wdata(in_beat.rx_byte),
		.raddr(ring_ra), .rdata(ring_rd)
	);
	mfp_ram #(.Depth(RingDepth)) u_pay (
		.clk(clk), .we(pay_we), .waddr(pay_wa), .wdata(ring_rd),
		.raddr(pay_ra), .rdata(pay_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{8'hC0, 8'h00, 16'h1021, 16'hFFFF, 8'd5};
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfp_pkg::REG_SYNC: cfg_q.sync_value <= cfg_data[7:0];
				mfp_pkg::REG_VERSION: cfg_q.version_value <= cfg_data[7:0];
				mfp_pkg::REG_POLY: cfg_q.crc_polynomial <= cfg_data;
				mfp_pkg::REG_CRC_START: cfg_q.crc_start <= cfg_data;
				mfp_pkg::REG_REBOOT: cfg_q.reboot_type_code <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfp_pkg::S_IDLE;
			rp_q <= '0;
			wp_q <= '0;
			hdr_q <= 1'b0;
			len_q <= '0;
			type_q <= '0;
			hcrc_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			rp_q <= rp_d;
			hdr_q <= hdr_d;
			len_q <= len_d;
			type_q <= type_d;
			hcrc_q <= hcrc_d;
			done <= done_d;
			if (ring_we) wp_q <= wp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) cmd_q <= in_beat;
		off_q <= off_d;
		crc_q <= crc_d;
		b0_q <= b0_d;
		ok_q <= ok_d;
		if (done_d) begin
			result.status <= stat_d;
			result.frame_length <= flen_d;
			result.frame_type <= type_d;
			result.data_byte <= dout_d;
			result.buffered_count <= 8'(wp_q + AW'(ring_we) - rp_d);
		end
	end

	assign busy = state_q != mfp_pkg::S_IDLE;

	always_comb begin
		state_d = state_q;
		rp_d = rp_q;
		hdr_d = hdr_q;
		len_d = len_q;
		type_d = type_q;
		hcrc_d = hcrc_q;
		off_d = off_q;
		crc_d = crc_q;
		b0_d = b0_q;
		ok_d = ok_q;
		stat_d = mfp_pkg::ST_NONE;
		dout_d = '0;
		flen_d = '0;
		done_d = 1'b0;
		ring_ra = rp_q + off_q;
		pay_we = 1'b0;
		pay_wa = off_q - AW'(mfp_pkg::HeaderBytes);
		pay_ra = cmd_q.read_index;
		unique case (state_q)
			mfp_pkg::S_IDLE: begin
				if (start) begin
					unique case (in_beat.op)
						mfp_pkg::OP_PUSH: state_d = mfp_pkg::S_DONE;
						mfp_pkg::OP_READ: state_d = mfp_pkg::S_PAY_RD;
						mfp_pkg::OP_PARSE: begin
							if (!hdr_q) begin
								state_d = (fill > AW'(mfp_pkg::HeaderBytes)) ?
									mfp_pkg::S_HDR_RD : mfp_pkg::S_DONE;
							end else if ({1'b0, fill} >= need) begin
								off_d = AW'(mfp_pkg::HeaderBytes);
								crc_d = cfg_q.crc_start;
								state_d = mfp_pkg::S_COPY_RD;
							end else begin
								state_d = mfp_pkg::S_DONE;
							end
							off_d = hdr_q ? AW'(mfp_pkg::HeaderBytes) : '0;
						end
						default: state_d = mfp_pkg::S_DONE;
					endcase
				end
			end
			mfp_pkg::S_DONE: begin
				done_d = 1'b1;
				stat_d = (cmd_q.op == mfp_pkg::OP_PUSH) ? mfp_pkg::ST_PUSHED :
					mfp_pkg::ST_NONE;
				state_d = mfp_pkg::S_IDLE;
			end
			mfp_pkg::S_PAY_RD: state_d = mfp_pkg::S_PAY_WAIT;
			mfp_pkg::S_PAY_WAIT: begin
				done_d = 1'b1;
				stat_d = mfp_pkg::ST_READ;
				dout_d = pay_rd;
				state_d = mfp_pkg::S_IDLE;
			end
			// header bytes streamed one per cycle at offsets 0..6; held fields
			// change only once sync and version matched
			mfp_pkg::S_HDR_RD: begin
				off_d = off_q + 1'b1;
				state_d = mfp_pkg::S_HDR_WAIT;
			end
			mfp_pkg::S_HDR_WAIT: begin
				off_d = off_q + 1'b1;
				unique case (off_q)
					AW'(1): b0_d = ring_rd;
					AW'(2): ok_d = (b0_q == cfg_q.sync_value) &&
						(ring_rd == cfg_q.version_value);
					AW'(4): if (ok_q) type_d = ring_rd;
					AW'(5): if (ok_q) len_d = ring_rd;
					AW'(6): if (ok_q) hcrc_d[15:8] = ring_rd;
					AW'(7): begin
						if (ok_q) hcrc_d[7:0] = ring_rd;
						state_d = mfp_pkg::S_HDR_CHK;
					end
					default: ;
				endcase
			end
			mfp_pkg::S_HDR_CHK: begin
				done_d = 1'b1;
				if (ok_q) begin
					hdr_d = 1'b1;
					stat_d = mfp_pkg::ST_HDR_OK;
				end else begin
					rp_d = rp_q + 1'b1;
					stat_d = mfp_pkg::ST_BAD_HDR;
				end
				state_d = mfp_pkg::S_IDLE;
			end
			mfp_pkg::S_COPY_RD: begin
				crc_d = cfg_q.crc_start;
				if (len_q == '0) begin
					off_d = AW'(mfp_pkg::HeaderBytes);
					state_d = mfp_pkg::S_REB_RD;
				end else begin
					state_d = mfp_pkg::S_COPY_WR;
				end
			end
			mfp_pkg::S_COPY_WR: begin
				pay_we = 1'b1;
				crc_d = mfp_pkg::crc_byte(crc_q, ring_rd, cfg_q.crc_polynomial);
				off_d = off_q + 1'b1;
				if ({1'b0, off_q} + 9'd1 == need) begin
					off_d = AW'(mfp_pkg::HeaderBytes);
					state_d = mfp_pkg::S_REB_RD;
				end else begin
					state_d = mfp_pkg::S_COPY_RD_N;
				end
			end
			mfp_pkg::S_COPY_RD_N: state_d = mfp_pkg::S_COPY_WR;
			mfp_pkg::S_REB_RD: state_d = mfp_pkg::S_REB_WAIT;
			mfp_pkg::S_REB_WAIT: begin
				done_d = 1'b1;
				hdr_d = 1'b0;
				state_d = mfp_pkg::S_IDLE;
				if (crc_q != hcrc_q) begin
					rp_d = rp_q + 1'b1;
					stat_d = mfp_pkg::ST_CRC_BAD;
				end else if (type_q == cfg_q.reboot_type_code) begin
					rp_d = rp_q + AW'(mfp_pkg::HeaderBytes + 1);
					stat_d = mfp_pkg::ST_REBOOT;
					dout_d = ring_rd;
				end else begin
					rp_d = rp_q + AW'(mfp_pkg::HeaderBytes) + len_q;
					stat_d = mfp_pkg::ST_DATA;
					flen_d = len_q;
				end
			end
			default: state_d = mfp_pkg::S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done)) else $error("result beat longer than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not raise busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		pay_we |-> state_q == mfp_pkg::S_COPY_WR) else $error("stray payload write");
endmodule
`default_nettype wire
